// File: sv/vonu_pkg.sv
// Types, constants and a helper function for the object name checker.
package vonu_pkg;

    // Longest accepted name in bytes; the count saturates one above it.
    localparam int MAX_NAME_BYTES = 1024;
    localparam int CNT_W          = $clog2(MAX_NAME_BYTES + 2);
    localparam int NAME_LEN_W     = 11;
    localparam int PREFIX_LEN     = 27;
    localparam int PREFIX_IDX_W   = $clog2(PREFIX_LEN);

    localparam logic [8*PREFIX_LEN-1:0] PREFIX_STR = ".well-known/acme-challenge/";

    localparam logic [7:0] CHR_LF       = 8'h0a;
    localparam logic [7:0] CHR_CR       = 8'h0d;
    localparam logic [7:0] CHR_DOT      = 8'h2e;
    localparam logic [7:0] ASCII_MAX    = 8'h7f;
    localparam logic [7:0] LEAD_MIN     = 8'hc2;
    localparam logic [7:0] LEAD_MAX     = 8'hf4;
    localparam logic [7:0] LEAD2_MAX    = 8'hdf;
    localparam logic [7:0] LEAD3_MAX    = 8'hef;
    localparam logic [7:0] LEAD_E0      = 8'he0;
    localparam logic [7:0] LEAD_ED      = 8'hed;
    localparam logic [7:0] LEAD_F0      = 8'hf0;
    localparam logic [7:0] LEAD_F4      = 8'hf4;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_EMPTY    = 3'd1,
        ERR_TOO_LONG = 3'd2,
        ERR_NEWLINE  = 3'd3,
        ERR_UTF8     = 3'd4,
        ERR_DOT      = 3'd5,
        ERR_DOTDOT   = 3'd6,
        ERR_PREFIX   = 3'd7
    } t_err_code;

    typedef enum logic [1:0] {
        SCAN_NONE    = 2'd0,
        SCAN_NEWLINE = 2'd1,
        SCAN_UTF8    = 2'd2
    } t_scan_err;

    typedef enum logic [2:0] {
        RANGE_80_BF = 3'd0,
        RANGE_A0_BF = 3'd1,
        RANGE_80_9F = 3'd2,
        RANGE_90_BF = 3'd3,
        RANGE_80_8F = 3'd4
    } t_tail_range;

    // Leading dot tracker: 0..2 dots so far, DOTS_OTHER for anything else.
    localparam logic [1:0] DOTS_OTHER = 2'd3;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       last;
        logic       empty_item;
    } t_in;

    typedef struct packed {
        logic [2:0]            error_code;
        logic [NAME_LEN_W-1:0] name_length;
    } t_out;

    function automatic logic [7:0] prefix_byte(input logic [PREFIX_IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        for (int k = 0; k < PREFIX_LEN; k++) begin
            if (idx == PREFIX_IDX_W'(k)) begin
                b = PREFIX_STR[8*(PREFIX_LEN-1-k) +: 8];
            end
        end
        return b;
    endfunction

endpackage

// File: sv/validate_object_name_utf8.sv
// Streaming object name checker: byte scan, UTF-8 rules and final verdict.
//
//   channel  | handshake             | payload            | role
//   ---------+-----------------------+--------------------+--------------------------
//   in       | i_in_valid/o_in_stall | i_in  (t_in)       | one name byte per item
//   out      | o_out_valid/i_out_stall | o_out (t_out)    | one verdict per name
//
// One item per cycle sustained unless o_out stalls. A closing item's verdict
// passes input register, then result register, and waits while o_out stalls.
// Reset clears the scan state and both valid flags; no clearing pass is needed.
// o_in_stall rises only while the input register holds an item and the result
// register is full and stalled.
module validate_object_name_utf8 (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  vonu_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output vonu_pkg::t_out  o_out
);
    import vonu_pkg::*;

    localparam logic [CNT_W-1:0] CNT_SAT    = CNT_W'(MAX_NAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_PREFIX = CNT_W'(PREFIX_LEN);

    logic         r_in_valid;
    t_in          r_in;
    logic         r_out_valid;
    t_out         r_out;

    logic [CNT_W-1:0] r_count,     n_count;
    logic [1:0]       r_tail_left, n_tail_left;
    t_tail_range      r_range,     n_range;
    t_scan_err        r_scan_err,  n_scan_err;
    logic             r_prefix_ok, n_prefix_ok;
    logic [1:0]       r_dots,      n_dots;

    logic       out_free;
    logic       in_move;
    logic [7:0] tail_lo;
    logic [7:0] tail_hi;
    logic [7:0] b;
    t_err_code  verdict;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_move    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign b           = r_in.name_byte;

    always_comb begin
        unique case (r_range)
            RANGE_A0_BF: begin tail_lo = 8'ha0; tail_hi = 8'hbf; end
            RANGE_80_9F: begin tail_lo = 8'h80; tail_hi = 8'h9f; end
            RANGE_90_BF: begin tail_lo = 8'h90; tail_hi = 8'hbf; end
            RANGE_80_8F: begin tail_lo = 8'h80; tail_hi = 8'h8f; end
            default:     begin tail_lo = 8'h80; tail_hi = 8'hbf; end
        endcase
    end

    // Scan state after taking the byte held in the input register.
    always_comb begin
        n_count     = r_count;
        n_tail_left = r_tail_left;
        n_range     = r_range;
        n_scan_err  = r_scan_err;
        n_prefix_ok = r_prefix_ok;
        n_dots      = r_dots;
        if (!r_in.empty_item) begin
            if (r_scan_err == SCAN_NONE) begin
                if (r_tail_left != 2'd0) begin
                    if (b < tail_lo || b > tail_hi) begin
                        n_scan_err = SCAN_UTF8;
                    end else begin
                        n_tail_left = r_tail_left - 2'd1;
                        n_range     = RANGE_80_BF;
                    end
                end else if (b <= ASCII_MAX) begin
                    if (b == CHR_LF || b == CHR_CR) begin
                        n_scan_err = SCAN_NEWLINE;
                    end
                end else if (b < LEAD_MIN || b > LEAD_MAX) begin
                    n_scan_err = SCAN_UTF8;
                end else if (b <= LEAD2_MAX) begin
                    n_tail_left = 2'd1;
                    n_range     = RANGE_80_BF;
                end else if (b <= LEAD3_MAX) begin
                    n_tail_left = 2'd2;
                    n_range     = (b == LEAD_E0) ? RANGE_A0_BF :
                                  (b == LEAD_ED) ? RANGE_80_9F : RANGE_80_BF;
                end else begin
                    n_tail_left = 2'd3;
                    n_range     = (b == LEAD_F0) ? RANGE_90_BF :
                                  (b == LEAD_F4) ? RANGE_80_8F : RANGE_80_BF;
                end
            end
            if (r_count < CNT_PREFIX &&
                b != prefix_byte(r_count[PREFIX_IDX_W-1:0])) begin
                n_prefix_ok = 1'b0;
            end
            if (r_dots != DOTS_OTHER) begin
                n_dots = (b == CHR_DOT) ? r_dots + 2'd1 : DOTS_OTHER;
            end
            if (r_count < CNT_SAT) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_comb begin
        if (n_count == '0) begin
            verdict = ERR_EMPTY;
        end else if (n_count == CNT_SAT) begin
            verdict = ERR_TOO_LONG;
        end else if (n_scan_err == SCAN_NEWLINE) begin
            verdict = ERR_NEWLINE;
        end else if (n_scan_err == SCAN_UTF8 || n_tail_left != 2'd0) begin
            verdict = ERR_UTF8;
        end else if (n_dots == 2'd1 && n_count == CNT_W'(1)) begin
            verdict = ERR_DOT;
        end else if (n_dots == 2'd2 && n_count == CNT_W'(2)) begin
            verdict = ERR_DOTDOT;
        end else if (n_prefix_ok && n_count >= CNT_PREFIX) begin
            verdict = ERR_PREFIX;
        end else begin
            verdict = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_tail_left <= 2'd0;
            r_range     <= RANGE_80_BF;
            r_scan_err  <= SCAN_NONE;
            r_prefix_ok <= 1'b1;
            r_dots      <= 2'd0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= in_move && r_in.last;
            end
            if (in_move) begin
                // Close the name: drop back to the start state.
                if (r_in.last) begin
                    r_count     <= '0;
                    r_tail_left <= 2'd0;
                    r_range     <= RANGE_80_BF;
                    r_scan_err  <= SCAN_NONE;
                    r_prefix_ok <= 1'b1;
                    r_dots      <= 2'd0;
                end else begin
                    r_count     <= n_count;
                    r_tail_left <= n_tail_left;
                    r_range     <= n_range;
                    r_scan_err  <= n_scan_err;
                    r_prefix_ok <= n_prefix_ok;
                    r_dots      <= n_dots;
                end
            end
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
        if (in_move && r_in.last) begin
            r_out.error_code  <= verdict;
            r_out.name_length <= NAME_LEN_W'(n_count);
        end
    end

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_move && r_in.last |=> r_out_valid)
        else $error("closing item did not produce a verdict");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_move && r_in.last |=> r_count == '0 && r_tail_left == 2'd0 &&
                                 r_scan_err == SCAN_NONE && r_prefix_ok)
        else $error("scan state not cleared after a name closed");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_SAT)
        else $error("byte count passed its saturation value");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("stalled verdict changed");

endmodule
